/* rtl/stereo_biquad_eq_chain_defines.svh */
// assertion helpers for the eq chain
`ifndef STEREO_BIQUAD_EQ_CHAIN_DEFINES_SVH
`define STEREO_BIQUAD_EQ_CHAIN_DEFINES_SVH

// same-cycle implication
`define SBEQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbeq_pkg.sv */
`timescale 1ns / 1ps
package sbeq_pkg;

    localparam int NUM_EQ_BANDS    = 10;
    localparam int NUM_SECTIONS    = NUM_EQ_BANDS + 3;
    localparam int SEC_BASS        = NUM_EQ_BANDS;
    localparam int SEC_LLOW        = NUM_EQ_BANDS + 1;
    localparam int SEC_LHIGH       = NUM_EQ_BANDS + 2;
    localparam int NUM_COEFFS      = 5;
    localparam int COEFF_DEPTH     = NUM_SECTIONS * NUM_COEFFS;
    localparam int STATE_DEPTH     = NUM_SECTIONS * 4;
    localparam int COEFF_AW        = $clog2(COEFF_DEPTH);
    localparam int STATE_AW        = $clog2(STATE_DEPTH);
    localparam int SEC_W           = 4;
    localparam int ENTRY_W         = STATE_AW - 1;

    localparam int SAMPLE_BITS     = 24;
    localparam int SIG_BITS        = SAMPLE_BITS + 4;
    localparam int STATE_BITS      = 40;
    localparam int STATE_GUARD     = 8;
    localparam int COEFF_BITS      = 32;
    localparam int COEFF_FRAC_BITS = 28;
    localparam int STATE_SHIFT     = COEFF_FRAC_BITS - STATE_GUARD;
    localparam int GAIN_FRAC       = 28;
    localparam int PROD_BITS       = SIG_BITS + 1 + COEFF_BITS;

    localparam logic [15:0] UNITY_PRE   = 16'd8192;
    localparam logic [15:0] UNITY_WIDTH = 16'd16384;

    // input word kinds
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEFF  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MASTER  = 3'd0;
    localparam logic [2:0] REG_ENABLES = 3'd1;
    localparam logic [2:0] REG_STEREO  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_BALANCE = 3'd4;
    localparam logic [2:0] REG_PREAMP  = 3'd5;
    localparam logic [2:0] REG_RAMP    = 3'd6;

    // coefficient slots
    localparam logic [2:0] CI_B0 = 3'd0;
    localparam logic [2:0] CI_B1 = 3'd1;
    localparam logic [2:0] CI_B2 = 3'd2;
    localparam logic [2:0] CI_A1 = 3'd3;
    localparam logic [2:0] CI_A2 = 3'd4;

    function automatic logic [STATE_DEPTH-1:0] state_mask(int first, int count);
        logic [STATE_DEPTH-1:0] m;
        m = '0;
        for (int ch = 0; ch < 2; ch++)
            for (int s = first; s < first + count; s++)
                for (int w = 0; w < 2; w++)
                    m[(ch * NUM_SECTIONS + s) * 2 + w] = 1'b1;
        return m;
    endfunction

    localparam logic [STATE_DEPTH-1:0] EQ_STATE_MASK   = state_mask(0, NUM_EQ_BANDS);
    localparam logic [STATE_DEPTH-1:0] LOUD_STATE_MASK = state_mask(SEC_LLOW, 2);

endpackage

/* rtl/sbeq_ram.sv */
`timescale 1ns / 1ps
module sbeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/stereo_biquad_eq_chain.sv */
`timescale 1ns / 1ps
// coefficient, clear and spare words are taken in the idle state and the input stays open;
// a master-off pair goes from accept straight to the output wait state, a pair with no active stage
// passes the ramp state first; a processed pair runs ramp, preamp, the section walk per channel,
// width, mono and balance in stereo, then load and the output wait, plus the divide (one quotient
// bit per cycle) when a new gain ramp starts; one word at a time, through the shared 29x32 multiplier
// reset (aresetn low, synchronous): registers to defaults, state reads as reset via valid bits
module stereo_biquad_eq_chain (
    input  logic        aclk,
    input  logic        aresetn,
    // sample / coefficient / clear words
    input  logic        s_tvalid,
    output logic        s_tready,
    // [23:0] left_sample, [47:24] right_sample, [51:48] section_index,
    // [54:52] coeff_index, [86:55] coeff_value, [87] zero
    input  logic [87:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    // processed pairs
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] left_out, [47:24] right_out
    output logic [47:0] m_tdata,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    `include "stereo_biquad_eq_chain_defines.svh"

    localparam int SW = sbeq_pkg::SIG_BITS;
    localparam int PW = sbeq_pkg::PROD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_RAMP, ST_GAIN, ST_SEL, ST_BQ,
        ST_WIDTH, ST_MONO, ST_BAL, ST_LOAD, ST_FINISH
    } state_t;

    // saturation helpers
    function automatic logic signed [SW-1:0] sat_sig(logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi[SW-1:0];
        if (v < lo) return lo[SW-1:0];
        return v[SW-1:0];
    endfunction

    function automatic logic signed [sbeq_pkg::STATE_BITS-1:0] sat_st(logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (sbeq_pkg::STATE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi[sbeq_pkg::STATE_BITS-1:0];
        if (v < lo) return lo[sbeq_pkg::STATE_BITS-1:0];
        return v[sbeq_pkg::STATE_BITS-1:0];
    endfunction

    function automatic logic [23:0] sat_out(logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'((1 << 23) - 1);
        lo = -hi - SW'(1);
        if (v > hi) return hi[23:0];
        if (v < lo) return lo[23:0];
        return v[23:0];
    endfunction

    // rounding offsets
    localparam logic signed [63:0] HALF_COEF  = 64'sd1 <<< (sbeq_pkg::COEFF_FRAC_BITS - 1);
    localparam logic signed [63:0] HALF_STATE = 64'sd1 <<< (sbeq_pkg::STATE_SHIFT - 1);
    localparam logic signed [63:0] HALF_GAIN  = 64'sd1 <<< (sbeq_pkg::GAIN_FRAC - 1);
    localparam logic signed [63:0] HALF_Q15   = 64'sd1 <<< 14;

    // configuration registers
    logic               master_on_reg;
    logic [3:0]         stage_en_reg;
    logic               stereo_on_reg;
    logic [15:0]        width_gain_reg;
    logic signed [15:0] balance_reg;
    logic [15:0]        preamp_reg;
    logic [11:0]        ramp_samples_reg;

    // control
    state_t             state_reg;
    logic [3:0]         step_reg;
    logic               ch_reg;
    logic [sbeq_pkg::SEC_W-1:0] sec_reg;
    logic [1:0]         prev_en_reg;
    logic [sbeq_pkg::COEFF_DEPTH-1:0] cvalid_reg;
    logic [sbeq_pkg::STATE_DEPTH-1:0] svalid_reg;
    logic               m_tvalid_reg;

    // gain ramp
    logic signed [31:0] cur_gain_reg;
    logic signed [31:0] ramp_tgt_reg;
    logic signed [31:0] gain_step_reg;
    logic [11:0]        ramp_left_reg;
    logic signed [31:0] g_reg;

    // divider
    logic               div_neg_reg;
    logic [31:0]        div_quo_reg;
    logic [11:0]        div_rem_reg;
    logic [4:0]         div_cnt_reg;

    // datapath
    logic signed [23:0]    xl_reg;
    logic signed [23:0]    xr_reg;
    logic signed [SW-1:0]  l_reg;
    logic signed [SW-1:0]  r_reg;
    logic signed [SW-1:0]  x_reg;
    logic signed [SW-1:0]  y_reg;
    logic signed [SW:0]    sum_reg;
    logic signed [31:0]    creg_reg;
    logic signed [sbeq_pkg::STATE_BITS-1:0] s1_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [63:0]    acc_reg;
    logic [23:0]           res_l_reg;
    logic [23:0]           res_r_reg;
    logic [47:0]           m_tdata_reg;
    logic                  c_vq_reg;
    logic                  c_b0q_reg;
    logic                  s_vq_reg;

    // input fields
    logic [1:0]         in_mode;
    logic signed [23:0] in_left;
    logic signed [23:0] in_right;
    logic [3:0]         in_sec;
    logic [2:0]         in_ci;
    logic [31:0]        in_cval;
    logic               in_acc;

    assign in_mode  = s_tuser;
    assign in_left  = s_tdata[23:0];
    assign in_right = s_tdata[47:24];
    assign in_sec   = s_tdata[51:48];
    assign in_ci    = s_tdata[54:52];
    assign in_cval  = s_tdata[86:55];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // stage decode
    logic eq_on, bass_on, loud_on, mono_on, tonal;
    logic signed [31:0] tgt_gain;
    logic signed [32:0] gain_diff;
    logic [32:0]        gain_mag;

    assign eq_on    = stage_en_reg[0];
    assign bass_on  = stage_en_reg[1];
    assign loud_on  = stage_en_reg[2];
    assign mono_on  = stage_en_reg[3];
    assign tgt_gain = {1'b0, preamp_reg, 15'b0};
    assign gain_diff = 33'(tgt_gain) - 33'(cur_gain_reg);
    assign gain_mag  = gain_diff[32] ? -gain_diff : gain_diff;
    assign tonal = eq_on || bass_on || loud_on || (preamp_reg != sbeq_pkg::UNITY_PRE) ||
                   (stereo_on_reg && ((width_gain_reg != sbeq_pkg::UNITY_WIDTH) ||
                                      mono_on || (balance_reg != 16'sd0)));

    // section enabled for the current slot
    logic sec_on;
    always_comb begin
        if (sec_reg < sbeq_pkg::SEC_W'(sbeq_pkg::NUM_EQ_BANDS)) sec_on = eq_on;
        else if (sec_reg == sbeq_pkg::SEC_W'(sbeq_pkg::SEC_BASS)) sec_on = bass_on;
        else sec_on = loud_on;
    end

    // coefficient memory, b0 reads as one until written
    logic                         coeff_we;
    logic [sbeq_pkg::COEFF_AW-1:0] coeff_waddr;
    logic [sbeq_pkg::COEFF_AW-1:0] coeff_raddr;
    logic [2:0]                   ci_sel;
    logic [31:0]                  c_rdata;
    logic signed [31:0]           cval;

    assign coeff_we = in_acc && (in_mode == sbeq_pkg::MODE_COEFF) &&
                      (in_sec < 4'(sbeq_pkg::NUM_SECTIONS)) &&
                      (in_ci < 3'(sbeq_pkg::NUM_COEFFS));
    assign coeff_waddr = sbeq_pkg::COEFF_AW'(in_sec) * sbeq_pkg::COEFF_AW'(sbeq_pkg::NUM_COEFFS)
                       + sbeq_pkg::COEFF_AW'(in_ci);

    // read order b0, b1, a1, b2, a2
    always_comb begin
        case (step_reg)
            4'd0:    ci_sel = sbeq_pkg::CI_B0;
            4'd1:    ci_sel = sbeq_pkg::CI_B1;
            4'd2:    ci_sel = sbeq_pkg::CI_A1;
            4'd3:    ci_sel = sbeq_pkg::CI_B2;
            default: ci_sel = sbeq_pkg::CI_A2;
        endcase
    end
    assign coeff_raddr = sbeq_pkg::COEFF_AW'(sec_reg) * sbeq_pkg::COEFF_AW'(sbeq_pkg::NUM_COEFFS)
                       + sbeq_pkg::COEFF_AW'(ci_sel);

    sbeq_ram #(
        .WIDTH(sbeq_pkg::COEFF_BITS),
        .DEPTH(sbeq_pkg::COEFF_DEPTH)
    ) u_coeff_ram (
        .aclk    (aclk),
        .wr_en   (coeff_we),
        .wr_addr (coeff_waddr),
        .wr_data (in_cval),
        .rd_addr (coeff_raddr),
        .rd_data (c_rdata)
    );

    always_comb begin
        if (c_vq_reg) cval = c_rdata;
        else if (c_b0q_reg) cval = 32'sd1 <<< sbeq_pkg::COEFF_FRAC_BITS;
        else cval = 32'sd0;
    end

    // filter state memory: entry = channel*sections + section, two words each
    logic [sbeq_pkg::ENTRY_W-1:0]  st_entry;
    logic [sbeq_pkg::STATE_AW-1:0] st_raddr;
    logic [sbeq_pkg::STATE_AW-1:0] st_waddr;
    logic                          st_we;
    logic [sbeq_pkg::STATE_BITS-1:0] st_wdata;
    logic [sbeq_pkg::STATE_BITS-1:0] st_rdata;
    logic signed [sbeq_pkg::STATE_BITS-1:0] sval;

    assign st_entry = ch_reg ? sbeq_pkg::ENTRY_W'(sec_reg) + sbeq_pkg::ENTRY_W'(sbeq_pkg::NUM_SECTIONS)
                             : sbeq_pkg::ENTRY_W'(sec_reg);
    assign st_raddr = {st_entry, step_reg == 4'd1};
    assign st_waddr = {st_entry, step_reg == 4'd8};
    assign st_we    = (state_reg == ST_BQ) && ((step_reg == 4'd6) || (step_reg == 4'd8));
    always_comb begin
        if (step_reg == 4'd6) st_wdata = sat_st((acc_reg >>> sbeq_pkg::STATE_SHIFT) + 64'(s1_reg));
        else st_wdata = sat_st(acc_reg >>> sbeq_pkg::STATE_SHIFT);
    end

    sbeq_ram #(
        .WIDTH(sbeq_pkg::STATE_BITS),
        .DEPTH(sbeq_pkg::STATE_DEPTH)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    assign sval = s_vq_reg ? st_rdata : '0;

    // shared multiplier operands
    logic signed [SW:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [16:0]  bal_fac;
    logic signed [SW:0]  l_ext, r_ext;

    assign l_ext = (SW+1)'(l_reg);
    assign r_ext = (SW+1)'(r_reg);
    assign bal_fac = (balance_reg > 16'sd0) ? 17'sd32768 - 17'(balance_reg)
                                            : 17'sd32768 + 17'(balance_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GAIN: begin
                mul_a = (step_reg == 4'd0) ? (SW+1)'(xl_reg) : (SW+1)'(xr_reg);
                mul_b = g_reg;
            end
            ST_BQ: begin
                case (step_reg)
                    4'd1: begin mul_a = (SW+1)'(x_reg); mul_b = cval; end
                    4'd2: begin mul_a = (SW+1)'(x_reg); mul_b = cval; end
                    4'd4: begin mul_a = (SW+1)'(y_reg); mul_b = creg_reg; end
                    4'd5: begin mul_a = (SW+1)'(x_reg); mul_b = creg_reg; end
                    4'd6: begin mul_a = (SW+1)'(y_reg); mul_b = creg_reg; end
                    default: ;
                endcase
            end
            ST_WIDTH: begin
                mul_a = l_ext - r_ext;
                mul_b = 32'(signed'({1'b0, width_gain_reg}));
            end
            ST_BAL: begin
                mul_a = (balance_reg > 16'sd0) ? l_ext : r_ext;
                mul_b = 32'(bal_fac);
            end
            default: ;
        endcase
    end

    logic signed [63:0] prod_ext;
    logic signed [63:0] sum_shl;
    logic [12:0]        div_try;
    logic [11:0]        ramp_dec;

    assign prod_ext = 64'(prod_reg);
    assign sum_shl  = 64'(sum_reg) <<< 14;
    assign div_try  = {div_rem_reg, div_quo_reg[31]};
    assign ramp_dec = ramp_left_reg - 12'd1;

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_on_reg    <= 1'b0;
            stage_en_reg     <= 4'd0;
            stereo_on_reg    <= 1'b1;
            width_gain_reg   <= sbeq_pkg::UNITY_WIDTH;
            balance_reg      <= 16'sd0;
            preamp_reg       <= sbeq_pkg::UNITY_PRE;
            ramp_samples_reg <= 12'd882;
            state_reg        <= ST_IDLE;
            step_reg         <= 4'd0;
            ch_reg           <= 1'b0;
            sec_reg          <= '0;
            prev_en_reg      <= 2'b00;
            cvalid_reg       <= '0;
            svalid_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
            cur_gain_reg     <= {1'b0, sbeq_pkg::UNITY_PRE, 15'b0};
            ramp_tgt_reg     <= {1'b0, sbeq_pkg::UNITY_PRE, 15'b0};
            gain_step_reg    <= 32'sd0;
            ramp_left_reg    <= 12'd0;
            div_cnt_reg      <= 5'd0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    sbeq_pkg::REG_MASTER:  master_on_reg    <= cfg_data[0];
                    sbeq_pkg::REG_ENABLES: stage_en_reg     <= cfg_data[3:0];
                    sbeq_pkg::REG_STEREO:  stereo_on_reg    <= cfg_data[0];
                    sbeq_pkg::REG_WIDTH:   width_gain_reg   <= cfg_data;
                    sbeq_pkg::REG_BALANCE: balance_reg      <= cfg_data;
                    sbeq_pkg::REG_PREAMP:  preamp_reg       <= cfg_data;
                    sbeq_pkg::REG_RAMP:    ramp_samples_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end

            // the output wait state handles its own handshake
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) m_tvalid_reg <= 1'b0;
            if (coeff_we) cvalid_reg[coeff_waddr] <= 1'b1;
            if (st_we) svalid_reg[st_waddr] <= 1'b1;

            prod_reg  <= mul_a * mul_b;
            c_vq_reg  <= cvalid_reg[coeff_raddr];
            c_b0q_reg <= (ci_sel == sbeq_pkg::CI_B0);
            s_vq_reg  <= svalid_reg[st_raddr];

            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= 4'd0;
                    if (in_acc) begin
                        xl_reg <= in_left;
                        xr_reg <= stereo_on_reg ? in_right : in_left;
                        case (in_mode)
                            sbeq_pkg::MODE_CLEAR: svalid_reg <= '0;
                            sbeq_pkg::MODE_SAMPLE: begin
                                if (!master_on_reg) begin
                                    res_l_reg <= in_left;
                                    res_r_reg <= stereo_on_reg ? in_right : in_left;
                                    state_reg <= ST_FINISH;
                                end else begin
                                    // state clear on a rising eq or loudness enable
                                    svalid_reg <= svalid_reg
                                        & ~((eq_on && !prev_en_reg[0]) ?
                                            sbeq_pkg::EQ_STATE_MASK : '0)
                                        & ~((loud_on && !prev_en_reg[1]) ?
                                            sbeq_pkg::LOUD_STATE_MASK : '0);
                                    prev_en_reg <= {loud_on, eq_on};
                                    state_reg   <= ST_RAMP;
                                    if (tgt_gain != ramp_tgt_reg) begin
                                        ramp_tgt_reg <= tgt_gain;
                                        if (ramp_samples_reg == 12'd0) begin
                                            cur_gain_reg  <= tgt_gain;
                                            ramp_left_reg <= 12'd0;
                                        end else begin
                                            ramp_left_reg <= ramp_samples_reg;
                                            div_neg_reg   <= gain_diff[32];
                                            div_quo_reg   <= gain_mag[31:0];
                                            div_rem_reg   <= 12'd0;
                                            div_cnt_reg   <= 5'd0;
                                            state_reg     <= ST_DIV;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // restoring divide, one quotient bit per cycle
                ST_DIV: begin
                    if (div_try >= {1'b0, ramp_samples_reg}) begin
                        div_rem_reg <= 12'(div_try - {1'b0, ramp_samples_reg});
                        div_quo_reg <= {div_quo_reg[30:0], 1'b1};
                    end else begin
                        div_rem_reg <= div_try[11:0];
                        div_quo_reg <= {div_quo_reg[30:0], 1'b0};
                    end
                    // count holds at the last bit so the ramp state loads the step
                    if (div_cnt_reg == 5'd31) begin
                        state_reg <= ST_RAMP;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                    end
                end

                ST_RAMP: begin
                    if (div_cnt_reg == 5'd31) begin
                        gain_step_reg <= div_neg_reg ? -signed'(div_quo_reg)
                                                     : signed'(div_quo_reg);
                        div_cnt_reg   <= 5'd0;
                    end else if (!tonal) begin
                        res_l_reg <= xl_reg;
                        res_r_reg <= xr_reg;
                        state_reg <= ST_FINISH;
                    end else begin
                        if (ramp_left_reg == 12'd0) begin
                            g_reg <= ramp_tgt_reg;
                        end else begin
                            ramp_left_reg <= ramp_dec;
                            if (ramp_dec != 12'd0) begin
                                cur_gain_reg <= cur_gain_reg + gain_step_reg;
                                g_reg        <= cur_gain_reg + gain_step_reg;
                            end else begin
                                cur_gain_reg <= ramp_tgt_reg;
                                g_reg        <= ramp_tgt_reg;
                            end
                        end
                        step_reg  <= 4'd0;
                        state_reg <= ST_GAIN;
                    end
                end

                // preamp: two products through the shared unit
                ST_GAIN: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: acc_reg <= prod_ext + HALF_GAIN;
                        4'd2: begin
                            l_reg   <= sat_sig(acc_reg >>> sbeq_pkg::GAIN_FRAC);
                            acc_reg <= prod_ext + HALF_GAIN;
                        end
                        4'd3: begin
                            r_reg     <= sat_sig(acc_reg >>> sbeq_pkg::GAIN_FRAC);
                            x_reg     <= l_reg;
                            ch_reg    <= 1'b0;
                            sec_reg   <= '0;
                            state_reg <= ST_SEL;
                        end
                        default: ;
                    endcase
                end

                // walk the section slots of one channel
                ST_SEL: begin
                    step_reg <= 4'd0;
                    if (sec_reg == sbeq_pkg::SEC_W'(sbeq_pkg::NUM_SECTIONS)) begin
                        sec_reg <= '0;
                        if (!ch_reg) begin
                            l_reg <= x_reg;
                            if (stereo_on_reg) begin
                                ch_reg <= 1'b1;
                                x_reg  <= r_reg;
                            end else begin
                                r_reg     <= x_reg;
                                state_reg <= ST_LOAD;
                            end
                        end else begin
                            r_reg     <= x_reg;
                            state_reg <= ST_WIDTH;
                        end
                    end else if (sec_on) begin
                        state_reg <= ST_BQ;
                    end else begin
                        sec_reg <= sec_reg + sbeq_pkg::SEC_W'(1);
                    end
                end

                // one tdf-ii section, nine steps
                ST_BQ: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: acc_reg <= (64'(sval) <<< sbeq_pkg::STATE_SHIFT) + HALF_COEF;
                        4'd2: begin
                            acc_reg <= acc_reg + prod_ext;
                            s1_reg  <= sval;
                        end
                        4'd3: begin
                            y_reg    <= sat_sig(acc_reg >>> sbeq_pkg::COEFF_FRAC_BITS);
                            acc_reg  <= prod_ext + HALF_STATE;
                            creg_reg <= cval;
                        end
                        4'd4: creg_reg <= cval;
                        4'd5: begin
                            acc_reg  <= acc_reg - prod_ext;
                            creg_reg <= cval;
                        end
                        4'd6: acc_reg <= prod_ext + HALF_STATE;
                        4'd7: acc_reg <= acc_reg - prod_ext;
                        4'd8: begin
                            x_reg     <= y_reg;
                            sec_reg   <= sec_reg + sbeq_pkg::SEC_W'(1);
                            state_reg <= ST_SEL;
                        end
                        default: ;
                    endcase
                end

                // mid/side width
                ST_WIDTH: begin
                    step_reg <= step_reg + 4'd1;
                    if (width_gain_reg == sbeq_pkg::UNITY_WIDTH) begin
                        state_reg <= ST_MONO;
                    end else begin
                        case (step_reg)
                            4'd0: sum_reg <= l_ext + r_ext;
                            4'd1: acc_reg <= sum_shl + prod_ext + HALF_Q15;
                            4'd2: begin
                                l_reg   <= sat_sig(acc_reg >>> 15);
                                acc_reg <= sum_shl - prod_ext + HALF_Q15;
                            end
                            4'd3: begin
                                r_reg     <= sat_sig(acc_reg >>> 15);
                                state_reg <= ST_MONO;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_MONO: begin
                    step_reg <= 4'd0;
                    if (mono_on) begin
                        l_reg <= SW'((l_ext + r_ext + (SW+1)'(1)) >>> 1);
                        r_reg <= SW'((l_ext + r_ext + (SW+1)'(1)) >>> 1);
                    end
                    state_reg <= ST_BAL;
                end

                // balance attenuates one side
                ST_BAL: begin
                    step_reg <= step_reg + 4'd1;
                    if (balance_reg == 16'sd0) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        case (step_reg)
                            4'd1: acc_reg <= prod_ext + HALF_Q15;
                            4'd2: begin
                                if (balance_reg > 16'sd0) l_reg <= SW'(acc_reg >>> 15);
                                else r_reg <= SW'(acc_reg >>> 15);
                                state_reg <= ST_LOAD;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_LOAD: begin
                    res_l_reg <= sat_out(l_reg);
                    res_r_reg <= sat_out(r_reg);
                    state_reg <= ST_FINISH;
                end

                // wait for the output register to free up
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_r_reg, res_l_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a result word appears only from the output wait state
    `SBEQ_ASSERT_NOW(a_out_src, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_FINISH), "output valid without finished pair")
    // an accepted sample pair keeps the input closed in the next cycle
    `SBEQ_ASSERT_NEXT(a_busy, aclk, aresetn, in_acc && (in_mode == sbeq_pkg::MODE_SAMPLE), !s_tready, "input ready right after a sample pair")
    // coefficient writes only come with an accepted word
    `SBEQ_ASSERT_NOW(a_coeff_wr, aclk, aresetn, coeff_we, s_tvalid && s_tready && (state_reg == ST_IDLE), "coefficient write outside accept")
    // the last state write of a section pass returns to the slot walk
    `SBEQ_ASSERT_NEXT(a_state_wr, aclk, aresetn, st_we && (step_reg == 4'd8), state_reg == ST_SEL, "section pass did not return to slot walk")

endmodule

/* tb/tb_stereo_biquad_eq_chain.sv */
`timescale 1ns / 1ps
module tb_stereo_biquad_eq_chain;
    import sbeq_pkg::*;

    // spare input kind, the block drops it
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } pair_t;

    // keeps its own copy of the equalizer state and the expected output pairs
    class eq_scoreboard;
        bit        master;
        bit [3:0]  enables;
        bit        stereo;
        bit [15:0] width;
        bit [15:0] balance;
        bit [15:0] preamp;
        bit [11:0] ramp_len;
        longint    coef [NUM_SECTIONS][5];
        longint    taps [2][NUM_SECTIONS][2];
        longint    gain, gain_goal, gain_inc;
        int        ramp_count;
        bit [1:0]  was_on;
        pair_t     pending_pairs[$];
        int        errors, pairs_seen;

        function new();
            master = 0; enables = 0; stereo = 1; width = UNITY_WIDTH;
            balance = 0; preamp = UNITY_PRE; ramp_len = 882;
            foreach (coef[s, c]) coef[s][c] = (c == 0) ? (64'sd1 <<< COEFF_FRAC_BITS) : 0;
            foreach (taps[c, s, w]) taps[c][s][w] = 0;
            gain = longint'(UNITY_PRE) <<< 15; gain_goal = gain; gain_inc = 0;
            ramp_count = 0; was_on = 0; errors = 0; pairs_seen = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [15:0] data);
            case (addr)
                REG_MASTER:  master = data[0];
                REG_ENABLES: enables = data[3:0];
                REG_STEREO:  stereo = data[0];
                REG_WIDTH:   width = data;
                REG_BALANCE: balance = data;
                REG_PREAMP:  preamp = data;
                REG_RAMP:    ramp_len = data[11:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        // round half up
        function longint rshift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function void wipe(int first, int count);
            for (int c = 0; c < 2; c++)
                for (int s = first; s < first + count; s++) begin
                    taps[c][s][0] = 0;
                    taps[c][s][1] = 0;
                end
        endfunction

        // transposed direct form two section
        function longint section(int sec, int ch, longint x);
            longint y;
            y = clip(rshift(x * coef[sec][0] + (taps[ch][sec][0] <<< STATE_SHIFT),
                            COEFF_FRAC_BITS), SIG_BITS);
            taps[ch][sec][0] = clip(rshift(x * coef[sec][1] - y * coef[sec][3], STATE_SHIFT)
                                    + taps[ch][sec][1], STATE_BITS);
            taps[ch][sec][1] = clip(rshift(x * coef[sec][2] - y * coef[sec][4], STATE_SHIFT),
                                    STATE_BITS);
            return y;
        endfunction

        function longint run_channel(int ch, longint v);
            if (enables[0])
                for (int b = 0; b < NUM_EQ_BANDS; b++) v = section(b, ch, v);
            if (enables[1]) v = section(SEC_BASS, ch, v);
            if (enables[2]) begin
                v = section(SEC_LLOW, ch, v);
                v = section(SEC_LHIGH, ch, v);
            end
            return v;
        endfunction

        // accepted input word
        function void note_word(logic [1:0] mode, logic [87:0] d);
            longint xl, xr, l, r, g, goal, bal, sum, dif;
            bit     active;
            pair_t  p;
            xl = longint'($signed(d[23:0]));
            xr = longint'($signed(d[47:24]));
            if (mode == MODE_COEFF) begin
                if (d[51:48] < NUM_SECTIONS && d[54:52] <= CI_A2)
                    coef[d[51:48]][d[54:52]] = longint'($signed(d[86:55]));
                return;
            end
            if (mode == MODE_CLEAR) begin
                wipe(0, NUM_SECTIONS);
                return;
            end
            if (mode != MODE_SAMPLE) return;
            if (!stereo) xr = xl;
            pairs_seen++;
            if (!master) begin
                p.left = xl[23:0]; p.right = xr[23:0];
                pending_pairs.push_back(p);
                return;
            end
            bal = longint'($signed(balance));
            if (enables[0] && !was_on[0]) wipe(0, NUM_EQ_BANDS);
            if (enables[2] && !was_on[1]) wipe(SEC_LLOW, 2);
            was_on = {enables[2], enables[0]};
            goal = longint'(preamp) <<< 15;
            if (goal != gain_goal) begin
                gain_goal = goal;
                if (ramp_len == 0) begin
                    gain = goal; ramp_count = 0;
                end else begin
                    ramp_count = ramp_len;
                    gain_inc = (goal - gain) / longint'(ramp_len);
                end
            end
            active = enables[2:0] != 0 || preamp != UNITY_PRE ||
                     (stereo && (width != UNITY_WIDTH || enables[3] || bal != 0));
            if (!active) begin
                p.left = xl[23:0]; p.right = xr[23:0];
                pending_pairs.push_back(p);
                return;
            end
            if (ramp_count == 0) g = gain_goal;
            else begin
                ramp_count--;
                if (ramp_count > 0) gain += gain_inc;
                else gain = gain_goal;
                g = gain;
            end
            l = clip(rshift(xl * g, GAIN_FRAC), SIG_BITS);
            r = stereo ? clip(rshift(xr * g, GAIN_FRAC), SIG_BITS) : l;
            l = run_channel(0, l);
            if (stereo) begin
                r = run_channel(1, r);
                if (width != UNITY_WIDTH) begin
                    sum = l + r; dif = l - r;
                    l = clip(rshift(sum * 16384 + dif * longint'(width), 15), SIG_BITS);
                    r = clip(rshift(sum * 16384 - dif * longint'(width), 15), SIG_BITS);
                end
                if (enables[3]) begin
                    l = rshift(l + r, 1);
                    r = l;
                end
                if (bal > 0) l = rshift(l * (32768 - bal), 15);
                else if (bal < 0) r = rshift(r * (32768 + bal), 15);
            end else r = l;
            l = clip(l, SAMPLE_BITS);
            r = clip(r, SAMPLE_BITS);
            p.left = l[23:0]; p.right = r[23:0];
            pending_pairs.push_back(p);
        endfunction

        // accepted output word
        function void check_pair(logic [47:0] d);
            pair_t got, want;
            got = d;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, d);
                errors++;
                return;
            end
            want = pending_pairs.pop_front();
            if (got.left !== want.left) begin
                $display("%0t: left_out expected %h actual %h", $time, want.left, got.left);
                errors++;
            end
            if (got.right !== want.right) begin
                $display("%0t: right_out expected %h actual %h", $time, want.right, got.right);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // left, right, section, coeff index, coeff value, pad
    logic [1:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // left_out, right_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_data;

    eq_scoreboard eq_sb;
    bit  idling_on;
    int  stall_left;
    int  quiet_cycles;
    int  words_sent;

    stereo_biquad_eq_chain dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitor: both sides sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) eq_sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) eq_sb.check_pair(m_tdata);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding",
                     eq_sb.pending_pairs.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure in short bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    task automatic write_reg(logic [2:0] addr, logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        eq_sb.write_reg(addr, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one word onto the input stream, with an optional gap ahead of it
    task automatic send_word(logic [1:0] mode, logic [23:0] left, logic [23:0] right,
                             logic [3:0] sec, logic [2:0] ci, logic [31:0] cv);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, cv, ci, sec, right, left};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every expected pair, then let a busy block settle
    task automatic drain();
        release_input();
        while (eq_sb.pending_pairs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(signed'($urandom_range(0, 4095)) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly well-behaved sections so the state does not just sit in saturation
    function automatic logic [31:0] rand_coeff(logic [2:0] ci);
        if ($urandom_range(0, 15) == 0) return $urandom;
        case (ci)
            CI_B0:   return 32'((64'sd1 <<< 28) + longint'($urandom_range(0, 1 << 27))
                            - (64'sd1 <<< 26));
            CI_A1:   return 32'(longint'($urandom_range(0, 1 << 28)) - (64'sd1 <<< 27));
            default: return 32'(longint'($urandom_range(0, 1 << 27)) - (64'sd1 <<< 26));
        endcase
    endfunction

    task automatic send_pair();
        send_word(MODE_SAMPLE, rand_sample(), rand_sample(), 4'($urandom), 3'($urandom),
                  $urandom);
    endtask

    task automatic send_coeff();
        logic [3:0] sec;
        logic [2:0] ci;
        sec = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, NUM_SECTIONS - 1))
                                         : 4'($urandom);
        ci  = $urandom_range(0, 7) < 7 ? 3'($urandom_range(0, 4)) : 3'($urandom);
        send_word(MODE_COEFF, 24'($urandom), 24'($urandom), sec, ci, rand_coeff(ci));
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78) send_pair();
        else if (pick < 93) send_coeff();
        else if (pick < 97) send_word(MODE_CLEAR, 24'($urandom), 24'($urandom),
                                      4'($urandom), 3'($urandom), $urandom);
        else send_word(MODE_SPARE, 24'($urandom), 24'($urandom), 4'($urandom),
                       3'($urandom), $urandom);
    endtask

    task automatic set_all(bit master, logic [3:0] en, bit stereo, logic [15:0] width,
                           logic [15:0] bal, logic [15:0] pre, logic [11:0] ramp);
        write_reg(REG_MASTER, {15'd0, master});
        write_reg(REG_ENABLES, {12'd0, en});
        write_reg(REG_STEREO, {15'd0, stereo});
        write_reg(REG_WIDTH, width);
        write_reg(REG_BALANCE, bal);
        write_reg(REG_PREAMP, pre);
        write_reg(REG_RAMP, {4'd0, ramp});
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) random_word();
    endtask

    initial begin
        eq_sb      = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_SAMPLE;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_addr   = REG_MASTER;
        cfg_data   = '0;
        idling_on  = 1'b1;
        stall_left = 0;
        quiet_cycles = 0;
        words_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults: master off, everything passes through
        random_phase(20);
        drain();

        // master on with unity settings, nothing active yet
        write_reg(REG_MASTER, 16'd1);
        random_phase(15);
        drain();

        // directed: every section, bad indexes, spare kind, clear, extreme samples
        set_all(1, 4'hF, 1, 16'd0, 16'h8000, 16'hFFFF, 12'd1);
        for (int s = 0; s < NUM_SECTIONS; s++)
            send_word(MODE_COEFF, 0, 0, 4'(s), 3'(s % 5), rand_coeff(3'(s % 5)));
        send_word(MODE_COEFF, 0, 0, 4'd15, CI_B0, 32'hFFFFFFFF);
        send_word(MODE_COEFF, 0, 0, 4'd0, 3'd7, 32'h80000000);
        send_word(MODE_SPARE, 24'h7FFFFF, 24'h800000, 0, 0, 0);
        send_word(MODE_SAMPLE, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0);
        send_word(MODE_SAMPLE, 24'h800000, 24'h800000, 0, 0, 0);
        send_word(MODE_SAMPLE, 24'h7FFFFF, 24'h800000, 0, 0, 0);
        send_word(MODE_CLEAR, 0, 0, 0, 0, 0);
        send_word(MODE_SAMPLE, 24'h000000, 24'hFFFFFF, 0, 0, 0);
        send_word(MODE_SAMPLE, 24'h000001, 24'h800000, 0, 0, 0);
        drain();

        set_all(1, 4'h0, 0, 16'd32768, 16'h7FFF, 16'd0, 12'd4095);
        random_phase(40);
        drain();

        // random settings, including eq and loudness toggles between phases
        for (int ph = 0; ph < 11; ph++) begin
            if (ph >= 8) idling_on = 1'b0;
            set_all($urandom_range(0, 7) != 0, 4'($urandom), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) == 0 ? UNITY_WIDTH : 16'($urandom_range(0, 32768)),
                    $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom),
                    $urandom_range(0, 2) == 0 ? UNITY_PRE : 16'($urandom),
                    12'($urandom_range(1, ph < 5 ? 60 : 4095)));
            random_phase(20);
            // hold off until the block has caught up, then continue
            if (ph == 3) begin
                release_input();
                while (eq_sb.pending_pairs.size() != 0) @(posedge aclk);
            end
            random_phase(22);
            drain();
        end

        $display("sent %0d input words, %0d sample pairs, over pass-through, ramp and",
                 words_sent, eq_sb.pairs_seen);
        $display("full-chain settings with coefficient updates and state clears");
        if (eq_sb.errors == 0 && eq_sb.pending_pairs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/sbeq_pkg.sv
rtl/sbeq_ram.sv
rtl/stereo_biquad_eq_chain.sv
tb/tb_stereo_biquad_eq_chain.sv
